@@ rtl/arpnh_pkg.sv @@
// Shared types and constants for the ARP next-hop cache.
// Used by every module of the block; depends on nothing.
`default_nettype none

package arpnh_pkg;

  // Field widths
  localparam int IP_W     = 32;
  localparam int MAC_W    = 48;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 2;

  // Default table depth
  localparam int ENTRIES_DEF = 16;

  // Depth of the queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Input function codes
  localparam logic FN_LEARN   = 1'b0;
  localparam logic FN_RESOLVE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GATEWAY = 2'd2;

  localparam logic [IP_W-1:0]  IP_ALL_ONES  = {IP_W{1'b1}};
  localparam logic [MAC_W-1:0] MAC_ALL_ONES = {MAC_W{1'b1}};

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_REPLACED = 3'd2,
    ST_HIT      = 3'd3,
    ST_BCAST    = 3'd4,
    ST_MISS     = 3'd5
  } status_t;

  // Kind of work the front hands to the back
  typedef enum logic [1:0] {
    OP_LEARN,
    OP_BCAST,
    OP_LOOKUP
  } op_kind_t;

  // One classified beat in the queue
  typedef struct packed {
    op_kind_t          kind;
    logic [IP_W-1:0]   target;
    logic [MAC_W-1:0]  mac;
  } op_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_CMP
  } bk_state_t;

endpackage

`default_nettype wire

@@ rtl/arpnh_front.sv @@
// Front end: configuration registers, input handshake and classification.
// Depends on arpnh_pkg; feeds arpnh_queue.
`default_nettype none

module arpnh_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration
  input  wire logic                               cfg_we,
  input  wire logic [arpnh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [arpnh_pkg::IP_W-1:0]         cfg_data,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_func,
  input  wire logic [arpnh_pkg::IP_W-1:0]         in_address,
  input  wire logic [arpnh_pkg::MAC_W-1:0]        in_learn_mac,
  // to queue
  output logic                                    push,
  output arpnh_pkg::op_t                          push_op,
  input  wire logic                               q_full
);

  logic [arpnh_pkg::IP_W-1:0] own_ip_r, mask_r, gateway_r;
  logic [arpnh_pkg::IP_W-1:0] subnet_bcast;
  logic                       is_bcast;
  logic                       off_subnet;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r  <= '0;
      mask_r    <= '0;
      gateway_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        arpnh_pkg::REG_OWN_IP:  own_ip_r  <= cfg_data;
        arpnh_pkg::REG_MASK:    mask_r    <= cfg_data;
        arpnh_pkg::REG_GATEWAY: gateway_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Take a beat whenever the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // Broadcast and subnet tests
  assign subnet_bcast = own_ip_r | ~mask_r;
  assign is_bcast     = (in_address == arpnh_pkg::IP_ALL_ONES) ||
                        (in_address == subnet_bcast);
  assign off_subnet   = (mask_r != '0) &&
                        ((in_address & mask_r) != (own_ip_r & mask_r));

  // Classify the beat
  always_comb begin
    push_op.mac    = in_learn_mac;
    push_op.target = in_address;
    if (in_func == arpnh_pkg::FN_LEARN) begin
      push_op.kind = arpnh_pkg::OP_LEARN;
    end else if (is_bcast) begin
      push_op.kind = arpnh_pkg::OP_BCAST;
    end else begin
      push_op.kind = arpnh_pkg::OP_LOOKUP;
      if (off_subnet) begin
        push_op.target = gateway_r;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/arpnh_queue.sv @@
// Short FIFO of classified beats between front and back.
// Depends on arpnh_pkg for the entry type and depth.
`default_nettype none

module arpnh_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire arpnh_pkg::op_t  push_op,
  output logic                 full,
  output logic                 not_empty,
  output arpnh_pkg::op_t       head_op,
  input  wire logic            pop
);

  arpnh_pkg::op_t                  slot_r [arpnh_pkg::QDEPTH];
  logic [arpnh_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [arpnh_pkg::QCNT_W-1:0]    cnt_r;
  logic                            do_push, do_pop;

  assign full      = (cnt_r == arpnh_pkg::QCNT_W'(arpnh_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_op   = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == arpnh_pkg::QPTR_W'(arpnh_pkg::QDEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == arpnh_pkg::QPTR_W'(arpnh_pkg::QDEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/arpnh_back.sv @@
// Back end: table memory, scan sequencer and the output register.
// Depends on arpnh_pkg; takes work from arpnh_queue.
`default_nettype none

module arpnh_back #(
  parameter int ENTRIES = arpnh_pkg::ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // from queue
  input  wire logic                              q_not_empty,
  input  wire arpnh_pkg::op_t                    q_head,
  output logic                                   q_pop,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [arpnh_pkg::STATUS_W-1:0]         out_status,
  output logic [arpnh_pkg::IP_W-1:0]             out_next_hop,
  output logic [arpnh_pkg::MAC_W-1:0]            out_resolved_mac
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // Table storage
  logic [arpnh_pkg::IP_W-1:0]  ip_mem  [ENTRIES];
  logic [arpnh_pkg::MAC_W-1:0] mac_mem [ENTRIES];
  logic [ENTRIES-1:0]          valid_r;
  logic [arpnh_pkg::IP_W-1:0]  ip_rd_r;
  logic [arpnh_pkg::MAC_W-1:0] mac_rd_r;

  // Sequencer state
  arpnh_pkg::bk_state_t state_r, state_nxt;
  arpnh_pkg::op_t       op_r;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 free_found_r, free_found_nxt;
  logic [IDX_W-1:0]     free_idx_r, free_idx_nxt;

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  arpnh_pkg::status_t            out_status_r, res_status;
  logic [arpnh_pkg::IP_W-1:0]    out_hop_r, res_hop;
  logic [arpnh_pkg::MAC_W-1:0]   out_mac_r, res_mac;
  logic                          load_out;

  // Memory control
  logic                 mem_re, mem_we;
  logic [IDX_W-1:0]     wr_idx;

  logic                 hit, last, cur_free, start;

  assign hit      = valid_r[idx_r] && (ip_rd_r == op_r.target);
  assign last     = (idx_r == LAST_IDX);
  assign cur_free = !valid_r[idx_r];
  assign start    = q_not_empty && !out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      arpnh_pkg::BK_IDLE: begin
        if (start && q_head.kind != arpnh_pkg::OP_BCAST) begin
          state_nxt = arpnh_pkg::BK_READ;
        end
      end
      arpnh_pkg::BK_READ: state_nxt = arpnh_pkg::BK_CMP;
      arpnh_pkg::BK_CMP: begin
        state_nxt = (hit || last) ? arpnh_pkg::BK_IDLE : arpnh_pkg::BK_READ;
      end
      default: state_nxt = arpnh_pkg::BK_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop          = 1'b0;
    mem_re         = 1'b0;
    mem_we         = 1'b0;
    wr_idx         = idx_r;
    load_out       = 1'b0;
    res_status     = arpnh_pkg::ST_MISS;
    res_hop        = '0;
    res_mac        = '0;
    idx_nxt        = idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    case (state_r)
      arpnh_pkg::BK_IDLE: begin
        if (start) begin
          q_pop          = 1'b1;
          idx_nxt        = '0;
          free_found_nxt = 1'b0;
          free_idx_nxt   = '0;
          // broadcast needs no table access
          if (q_head.kind == arpnh_pkg::OP_BCAST) begin
            load_out   = 1'b1;
            res_status = arpnh_pkg::ST_BCAST;
            res_hop    = q_head.target;
            res_mac    = arpnh_pkg::MAC_ALL_ONES;
          end
        end
      end
      arpnh_pkg::BK_READ: mem_re = 1'b1;
      arpnh_pkg::BK_CMP: begin
        if (hit) begin
          load_out = 1'b1;
          if (op_r.kind == arpnh_pkg::OP_LEARN) begin
            mem_we     = 1'b1;
            res_status = arpnh_pkg::ST_UPDATED;
          end else begin
            res_status = arpnh_pkg::ST_HIT;
            res_hop    = op_r.target;
            res_mac    = mac_rd_r;
          end
        end else if (last) begin
          load_out = 1'b1;
          if (op_r.kind == arpnh_pkg::OP_LEARN) begin
            mem_we = 1'b1;
            if (free_found_r) begin
              wr_idx     = free_idx_r;
              res_status = arpnh_pkg::ST_INSERTED;
            end else if (cur_free) begin
              res_status = arpnh_pkg::ST_INSERTED;
            end else begin
              wr_idx     = '0;
              res_status = arpnh_pkg::ST_REPLACED;
            end
          end else begin
            res_status = arpnh_pkg::ST_MISS;
            res_hop    = op_r.target;
          end
        end else begin
          // keep the lowest free slot seen so far
          idx_nxt = idx_r + 1'b1;
          if (!free_found_r && cur_free) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = idx_r;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Table memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ip_mem[wr_idx]  <= op_r.target;
      mac_mem[wr_idx] <= op_r.mac;
    end
    if (mem_re) begin
      ip_rd_r  <= ip_mem[idx_r];
      mac_rd_r <= mac_mem[idx_r];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= arpnh_pkg::BK_IDLE;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      idx_r        <= idx_nxt;
      free_found_r <= free_found_nxt;
      free_idx_r   <= free_idx_nxt;
      if (mem_we) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r <= q_head;
    end
    if (load_out) begin
      out_status_r <= res_status;
      out_hop_r    <= res_hop;
      out_mac_r    <= res_mac;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_next_hop     = out_hop_r;
  assign out_resolved_mac = out_mac_r;

endmodule

`default_nettype wire

@@ rtl/arp_next_hop_cache.sv @@
// Top level of the ARP next-hop cache: front, queue and back joined.
// Depends on arpnh_pkg, arpnh_front, arpnh_queue and arpnh_back.
//
//   Channel | Handshake            | Payload
//   in_     | in_valid/in_ready    | func, address, learn_mac
//   out_    | out_valid/out_ready  | status, next_hop, resolved_mac
//   cfg_    | cfg_we (no wait)     | cfg_index, cfg_data
//
// A learn or resolve beat holds the back end from its pop through a read and a compare
// per entry (a hit stops the scan). The back end pops no new beat until the result has
// left the output register; a broadcast resolve needs no table access. Reset clears the
// valid marks at once.
// A two-beat queue lets the input keep accepting while a result waits.
`default_nettype none

module arp_next_hop_cache #(
  parameter int ENTRIES = arpnh_pkg::ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [arpnh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [arpnh_pkg::IP_W-1:0]        cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_func,
  input  wire logic [arpnh_pkg::IP_W-1:0]        in_address,
  input  wire logic [arpnh_pkg::MAC_W-1:0]       in_learn_mac,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [arpnh_pkg::STATUS_W-1:0]         out_status,
  output logic [arpnh_pkg::IP_W-1:0]             out_next_hop,
  output logic [arpnh_pkg::MAC_W-1:0]            out_resolved_mac
);

  logic           push, q_full, q_not_empty, q_pop;
  arpnh_pkg::op_t push_op, q_head;

  arpnh_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_address   (in_address),
    .in_learn_mac (in_learn_mac),
    .push         (push),
    .push_op      (push_op),
    .q_full       (q_full)
  );

  arpnh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_op   (push_op),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_op   (q_head),
    .pop       (q_pop)
  );

  arpnh_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_next_hop     (out_next_hop),
    .out_resolved_mac (out_resolved_mac)
  );

`ifndef ASSERT_OFF
  // Broadcast results always carry the all-ones MAC
  a_bcast_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == arpnh_pkg::ST_BCAST) |->
      (out_resolved_mac == arpnh_pkg::MAC_ALL_ONES))
    else $error("broadcast result without all-ones MAC");

  // Learn results report zero next hop and zero MAC
  a_learn_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == arpnh_pkg::ST_UPDATED ||
                   out_status == arpnh_pkg::ST_INSERTED ||
                   out_status == arpnh_pkg::ST_REPLACED)) |->
      (out_next_hop == '0 && out_resolved_mac == '0))
    else $error("learn result with nonzero payload");

  // A miss never reports a MAC
  a_miss_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == arpnh_pkg::ST_MISS) |-> (out_resolved_mac == '0))
    else $error("miss result with nonzero MAC");

  // The back end only pops the queue while the output register is free
  a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!out_valid && q_not_empty))
    else $error("queue popped while result pending");
`endif

endmodule

`default_nettype wire

@@ sim/arp_next_hop_cache_test.sv @@
// Self-checking testbench for arp_next_hop_cache: learn/resolve beats against
// a table predictor over several address settings. Depends on arpnh_pkg and the RTL.
module arp_next_hop_cache_test;
  import arpnh_pkg::*;

  localparam int TBL_DEPTH = ENTRIES_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 600;
  localparam int POOL_SIZE = 24;
  // Index past the last register; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic              func;
    logic [IP_W-1:0]   address;
    logic [MAC_W-1:0]  mac;
  } arp_req_t;

  typedef struct {
    status_t           status;
    logic [IP_W-1:0]   next_hop;
    logic [MAC_W-1:0]  mac;
  } arp_reply_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE
  } rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [IP_W-1:0]      cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_func;
  logic [IP_W-1:0]      in_address;
  logic [MAC_W-1:0]     in_learn_mac;
  logic                 out_valid;
  logic                 out_ready;
  logic [STATUS_W-1:0]  out_status;
  logic [IP_W-1:0]      out_next_hop;
  logic [MAC_W-1:0]     out_resolved_mac;

  arp_next_hop_cache dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_address       (in_address),
    .in_learn_mac     (in_learn_mac),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_next_hop     (out_next_hop),
    .out_resolved_mac (out_resolved_mac)
  );

  // Predictor copy of the table and the address registers
  logic             tbl_valid [TBL_DEPTH];
  logic [IP_W-1:0]  tbl_ip    [TBL_DEPTH];
  logic [MAC_W-1:0] tbl_mac   [TBL_DEPTH];
  logic [IP_W-1:0]  my_ip;
  logic [IP_W-1:0]  net_mask;
  logic [IP_W-1:0]  gw_ip;

  arp_req_t   req_q[$];
  arp_reply_t reply_due_q[$];
  arp_req_t   drv_item;

  int n_issued;
  int n_accepted;
  int n_replies;
  int n_learn;
  int n_resolve;
  int n_settings;
  int fail_count;
  int idle_cycles;
  int status_seen [8];

  logic     in_taken;
  int       burst_left;
  int       gap_left;
  rx_mode_t rx_mode;
  int       mode_left;
  int       hold_left;
  logic     hold_done;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Lowest valid entry holding the address, or -1
  function automatic int find_slot(logic [IP_W-1:0] ip);
    int slot;
    slot = -1;
    for (int i = TBL_DEPTH - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_ip[i] == ip) slot = i;
    end
    return slot;
  endfunction

  // Applies one beat to the table copy and returns the reply it must produce
  function automatic arp_reply_t table_apply(arp_req_t r);
    arp_reply_t y;
    int slot;
    logic [IP_W-1:0] target;
    y.status = ST_MISS;
    y.next_hop = '0;
    y.mac = '0;
    if (r.func == FN_LEARN) begin
      slot = find_slot(r.address);
      if (slot >= 0) begin
        tbl_mac[slot] = r.mac;
        y.status = ST_UPDATED;
      end else begin
        slot = 0;
        y.status = ST_REPLACED;
        for (int i = TBL_DEPTH - 1; i >= 0; i--) begin
          if (!tbl_valid[i]) begin
            slot = i;
            y.status = ST_INSERTED;
          end
        end
        tbl_valid[slot] = 1'b1;
        tbl_ip[slot] = r.address;
        tbl_mac[slot] = r.mac;
      end
    end else if (r.address == IP_ALL_ONES || r.address == (my_ip | ~net_mask)) begin
      y.status = ST_BCAST;
      y.next_hop = r.address;
      y.mac = MAC_ALL_ONES;
    end else begin
      target = r.address;
      if (net_mask != '0 && (r.address & net_mask) != (my_ip & net_mask)) target = gw_ip;
      y.next_hop = target;
      slot = find_slot(target);
      if (slot >= 0) begin
        y.status = ST_HIT;
        y.mac = tbl_mac[slot];
      end
    end
    return y;
  endfunction

  task automatic push_req(logic func, logic [IP_W-1:0] addr, logic [MAC_W-1:0] mac);
    arp_req_t r;
    r.func = func;
    r.address = addr;
    r.mac = mac;
    req_q.push_back(r);
    n_issued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [IP_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_OWN_IP: my_ip = val;
      REG_MASK: net_mask = val;
      REG_GATEWAY: gw_ip = val;
      default: ;
    endcase
  endtask

  // Block is idle here; spare index gets junk that must not land anywhere
  task automatic set_config(logic [IP_W-1:0] own, logic [IP_W-1:0] mask,
                            logic [IP_W-1:0] gw);
    write_reg(REG_OWN_IP, own);
    write_reg(REG_MASK, mask);
    write_reg(REG_GATEWAY, gw);
    write_reg(REG_SPARE, $urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (n_accepted != n_issued || n_replies != n_accepted) @(negedge clk);
  endtask

  // Random beats drawn mostly from a pool of addresses that matter under the
  // current setting, so updates, hits, gateway use and evictions all recur
  task automatic run_phase(int n_items);
    logic [IP_W-1:0]  pool [POOL_SIZE];
    logic [MAC_W-1:0] mac;
    int pick;
    pool[0] = gw_ip;
    pool[1] = my_ip;
    pool[2] = IP_ALL_ONES;
    pool[3] = my_ip | ~net_mask;
    for (int k = 4; k < POOL_SIZE; k++) begin
      if (k < 16) pool[k] = (my_ip & net_mask) | ($urandom & ~net_mask);
      else pool[k] = $urandom;
    end
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      mac = {$urandom, $urandom};
      if ($urandom_range(0, 19) == 0) mac = ($urandom_range(0, 1) != 0) ? MAC_ALL_ONES : '0;
      if (pick < 45) push_req(FN_LEARN, pool[$urandom_range(0, POOL_SIZE - 1)], mac);
      else if (pick < 90) push_req(FN_RESOLVE, pool[$urandom_range(0, POOL_SIZE - 1)], mac);
      else push_req(logic'($urandom_range(0, 1)), $urandom, mac);
    end
    wait_idle();
  endtask

  // Sender: bursts of random length with random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0 || req_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        drv_item = req_q.pop_front();
        in_valid <= 1'b1;
        in_func <= drv_item.func;
        in_address <= drv_item.address;
        in_learn_mac <= drv_item.mac;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
  end

  // Receiver: own stall pattern, plus one long hold while beats keep coming
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && n_replies >= 400 && req_q.size() > 20) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(40, 300);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_COIN: out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Monitor: check reply beats, predict on accepted request beats, watchdog
  always @(posedge clk) begin
    arp_req_t   got_req;
    arp_reply_t want;
    if (rst_n) begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        n_replies++;
        status_seen[out_status]++;
        if (reply_due_q.size() == 0) begin
          $error("reply beat with nothing expected: status %0d", out_status);
          fail_count++;
        end else begin
          want = reply_due_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (out_next_hop !== want.next_hop) begin
            $error("next_hop: expected %h, got %h", want.next_hop, out_next_hop);
            fail_count++;
          end
          if (out_resolved_mac !== want.mac) begin
            $error("resolved_mac: expected %h, got %h", want.mac, out_resolved_mac);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        got_req.func = in_func;
        got_req.address = in_address;
        got_req.mac = in_learn_mac;
        reply_due_q.push_back(table_apply(got_req));
        n_accepted++;
        if (in_func == FN_LEARN) n_learn++;
        else n_resolve++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
          $display("arp_next_hop_cache_test: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [IP_W-1:0] own;
    logic [IP_W-1:0] mask;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_OWN_IP;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_func <= FN_LEARN;
    in_address <= '0;
    in_learn_mac <= '0;
    out_ready <= 1'b0;
    in_taken = 1'b0;
    burst_left = 0;
    gap_left = 0;
    rx_mode = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    idle_cycles = 0;
    my_ip = '0;
    net_mask = '0;
    gw_ip = '0;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_ip[i] = '0;
      tbl_mac[i] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values: zero mask, so only all-ones is broadcast
    n_settings = 1;
    run_phase(150);

    // Directed: /24 subnet, fill the table, evict entry 0, broadcasts
    set_config(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101);
    push_req(FN_RESOLVE, 32'hC0A8_0105, '0);
    push_req(FN_LEARN, 32'hC0A8_0101, '0);
    push_req(FN_LEARN, 32'hC0A8_0101, MAC_ALL_ONES);
    push_req(FN_RESOLVE, 32'h0808_0808, 48'h1234_5678_9ABC);
    push_req(FN_RESOLVE, IP_ALL_ONES, '0);
    push_req(FN_RESOLVE, 32'hC0A8_01FF, '0);
    push_req(FN_RESOLVE, 32'h0000_0000, '0);
    for (int i = 0; i < TBL_DEPTH - 1; i++) begin
      push_req(FN_LEARN, 32'hC0A8_0114 + i, {16'hA5A5, 32'(i)});
    end
    push_req(FN_LEARN, 32'hC0A8_0163, 48'h5A5A_0000_FFFF);
    push_req(FN_RESOLVE, 32'h0101_0101, '0);
    push_req(FN_RESOLVE, 32'hC0A8_0114, '0);
    run_phase(150);

    // Host mask: resolves of anything but the own and all-ones addresses go to the gateway
    set_config(32'h0A00_0001, IP_ALL_ONES, 32'h0A00_00FE);
    run_phase(200);

    // All-ones own address, one-bit mask, zero gateway
    set_config(IP_ALL_ONES, 32'h8000_0000, '0);
    run_phase(200);

    // Zero mask written explicitly; the gateway is never used
    set_config('0, '0, IP_ALL_ONES);
    run_phase(200);

    // Random prefixes, gateway inside or outside the subnet
    for (int p = 0; p < 4; p++) begin
      own = $urandom;
      mask = IP_ALL_ONES << $urandom_range(1, 31);
      set_config(own, mask, ($urandom_range(0, 1) != 0) ?
                 ((own & mask) | ($urandom & ~mask)) : $urandom);
      run_phase(200);
    end

    wait_idle();
    repeat (2 * TBL_DEPTH + 40) @(negedge clk);
    if (reply_due_q.size() != 0) begin
      $error("%0d expected replies never arrived", reply_due_q.size());
      fail_count++;
    end
    $display("covered %0d request beats (%0d learn, %0d resolve) under %0d address settings",
             n_accepted, n_learn, n_resolve, n_settings);
    $display("replies: updated %0d, inserted %0d, replaced %0d, hit %0d, broadcast %0d, miss %0d",
             status_seen[ST_UPDATED], status_seen[ST_INSERTED], status_seen[ST_REPLACED],
             status_seen[ST_HIT], status_seen[ST_BCAST], status_seen[ST_MISS]);
    if (fail_count == 0) begin
      $display("arp_next_hop_cache_test: PASS");
    end else begin
      $display("arp_next_hop_cache_test: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/arpnh_pkg.sv
rtl/arpnh_front.sv
rtl/arpnh_queue.sv
rtl/arpnh_back.sv
rtl/arp_next_hop_cache.sv
sim/arp_next_hop_cache_test.sv
